[rtl/msle_pkg.sv]
package msle_pkg;

	// Default and largest supported macro name length, in characters
	localparam int unsigned MAX_NAME_LEN_DEF = 8;

	// Configuration register width and indexes
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_CHARS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_LENGTH = 1'd1;

	// Result kinds
	localparam logic [1:0] KIND_LIT_BYTE  = 2'd0;
	localparam logic [1:0] KIND_LIT_END   = 2'd1;
	localparam logic [1:0] KIND_BAD_TOKEN = 2'd2;
	localparam logic [1:0] KIND_BSL_EOF   = 2'd3;

	// Characters of interest
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_MATCH,
		MODE_AFTER_NAME,
		MODE_MACRO
	} scan_mode_t;

	// Scanner state apart from the name match counter
	typedef struct packed {
		scan_mode_t mode;
		logic       quote_open;
		logic       skip_next;
		logic       keep_escaped;
		logic       error_seen;
		logic [7:0] previous_byte;
	} scan_state_t;

	// One result item
	typedef struct packed {
		logic       valid;
		logic [1:0] kind;
		logic [7:0] data;
	} scan_result_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h61 && c <= 8'h7A);
	endfunction

endpackage

[rtl/msle_step.sv]
module msle_step #(
	parameter int unsigned MAX_NAME_LEN = msle_pkg::MAX_NAME_LEN_DEF,
	localparam int unsigned CNT_W = $clog2(MAX_NAME_LEN + 1),
	localparam int unsigned IDX_W = (MAX_NAME_LEN > 1) ? $clog2(MAX_NAME_LEN) : 1
) (
	input  msle_pkg::scan_state_t       state,
	input  logic [CNT_W-1:0]            count,
	input  logic [MAX_NAME_LEN-1:0][7:0] name,
	input  logic [CNT_W-1:0]            name_len,
	input  logic [7:0]                  text_byte,
	input  logic                        end_of_file,
	output msle_pkg::scan_state_t       state_nxt,
	output logic [CNT_W-1:0]            count_nxt,
	output msle_pkg::scan_result_t      result
);
	import msle_pkg::*;

	logic [7:0]       name_ch;
	logic [CNT_W-1:0] count_start;
	logic [CNT_W-1:0] count_inc;
	logic             name_hit;
	logic             name_done;
	logic             macro_body;

	// Compare against the name character at the current (or restarted) position
	always_comb begin
		count_start = (state.mode == MODE_MATCH) ? count : '0;
		name_ch     = name[count_start[IDX_W-1:0]];
		name_hit    = (text_byte == name_ch);
		count_inc   = count_start + 1'b1;
		name_done   = (count_inc >= name_len);
		macro_body  = (state.mode == MODE_MACRO);
	end

	// One scan step per item
	always_comb begin
		state_nxt = state;
		count_nxt = count;
		result    = '{valid: 1'b0, kind: KIND_LIT_BYTE, data: 8'h00};

		priority if (state.error_seen) begin
			// rest of file ignored
		end else if (state.skip_next) begin
			state_nxt.skip_next = 1'b0;
		end else if (state.keep_escaped) begin
			state_nxt.keep_escaped = 1'b0;
			result = '{valid: 1'b1, kind: KIND_LIT_BYTE, data: text_byte};
		end else if (state.mode == MODE_MATCH) begin
			if (name_hit) begin
				count_nxt      = count_inc;
				state_nxt.mode = name_done ? MODE_AFTER_NAME : MODE_MATCH;
			end else begin
				state_nxt.mode = MODE_NORMAL;
			end
		end else if (state.mode == MODE_AFTER_NAME) begin
			if (text_byte == CH_BSLASH) begin
				state_nxt.skip_next = 1'b1;
			end else if (!is_space(text_byte)) begin
				state_nxt.mode = (text_byte == CH_LPAREN) ? MODE_MACRO : MODE_NORMAL;
			end
		end else if (text_byte == CH_BSLASH) begin
			if (macro_body && state.quote_open) begin
				if (end_of_file) begin
					result = '{valid: 1'b1, kind: KIND_BSL_EOF, data: 8'h00};
					state_nxt.error_seen = 1'b1;
				end else begin
					result = '{valid: 1'b1, kind: KIND_LIT_BYTE, data: text_byte};
					state_nxt.keep_escaped = 1'b1;
				end
			end else begin
				state_nxt.skip_next = 1'b1;
			end
		end else if (text_byte == CH_QUOTE) begin
			state_nxt.quote_open = !state.quote_open;
		end else if (state.quote_open) begin
			if (macro_body) begin
				result = '{valid: 1'b1, kind: KIND_LIT_BYTE, data: text_byte};
			end
		end else if (macro_body) begin
			if (text_byte == CH_RPAREN) begin
				result = '{valid: 1'b1, kind: KIND_LIT_END, data: 8'h00};
				state_nxt.mode = MODE_NORMAL;
			end else if (!is_space(text_byte)) begin
				result = '{valid: 1'b1, kind: KIND_BAD_TOKEN, data: text_byte};
				state_nxt.error_seen = 1'b1;
			end
		end else if (!is_alnum(state.previous_byte)) begin
			// word boundary: restart the name match
			if (name_hit) begin
				count_nxt      = count_inc;
				state_nxt.mode = name_done ? MODE_AFTER_NAME : MODE_MATCH;
			end else begin
				count_nxt      = '0;
				state_nxt.mode = MODE_NORMAL;
			end
		end else begin
			// inside a word: no match can start here
		end

		state_nxt.previous_byte = text_byte;

		// end of file clears the parse
		if (end_of_file) begin
			state_nxt = '{mode: MODE_NORMAL, quote_open: 1'b0, skip_next: 1'b0,
				keep_escaped: 1'b0, error_seen: 1'b0, previous_byte: 8'h00};
			count_nxt = '0;
		end
	end

endmodule

[rtl/macro_string_literal_extractor.sv]
// Macro string literal extractor.
// Input channel (in_valid/in_ready): one text byte per item, with end_of_file
// set on the last byte of a file. The block finds the configured macro name at
// a word boundary, followed by optional whitespace and '(', and streams the
// bytes of the quoted strings inside it on the output channel
// (out_valid/out_ready), one result item per literal byte, plus an end item at
// the closing ')' or an error item for a bad token or a trailing backslash.
// Each input item gives zero or one result item.
// Latency: a result is presented the cycle after its input item is accepted.
// Throughput: one item per cycle unless the receiver stalls; the whole scan step
// is one combinational pass between the input handshake and the output register.
// When the receiver stalls, the output register holds its item and in_ready
// drops until it is taken; in_ready is high whenever the output register is
// empty or being emptied in the same cycle.
// The user must write configuration (cfg_write/cfg_index/cfg_data) while idle;
// the block itself does not enforce this. Register 0 holds the name bytes,
// first character lowest; register 1 its length. Reset clears the scan state and
// the output valid flag, and sets the name to all zero bytes and the length to one.
module macro_string_literal_extractor #(
	parameter int unsigned MAX_NAME_LEN = msle_pkg::MAX_NAME_LEN_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [7:0]                           text_byte,
	input  logic                                 end_of_file,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           result_kind,
	output logic [7:0]                           result_byte,
	input  logic                                 cfg_write,
	input  logic [msle_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msle_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import msle_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_NAME_LEN + 1);

	logic [MAX_NAME_LEN-1:0][7:0] name_q;
	logic [3:0]                   len_q;
	logic [CNT_W-1:0]             eff_len;
	scan_state_t                  state_q;
	scan_state_t                  state_nxt;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_nxt;
	scan_result_t                 step_res;
	logic                         out_valid_q;
	logic [1:0]                   out_kind_q;
	logic [7:0]                   out_byte_q;
	logic                         accept;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q <= '0;
			len_q  <= 4'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_NAME_CHARS:  name_q <= cfg_data[8*MAX_NAME_LEN-1:0];
				REG_NAME_LENGTH: len_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Length clamped to 1..MAX_NAME_LEN
	always_comb begin
		if (len_q == 4'd0) begin
			eff_len = CNT_W'(1);
		end else if ({28'd0, len_q} > MAX_NAME_LEN) begin
			eff_len = CNT_W'(MAX_NAME_LEN);
		end else begin
			eff_len = len_q[CNT_W-1:0];
		end
	end

	msle_step #(
		.MAX_NAME_LEN(MAX_NAME_LEN)
	) u_step (
		.state      (state_q),
		.count      (count_q),
		.name       (name_q),
		.name_len   (eff_len),
		.text_byte  (text_byte),
		.end_of_file(end_of_file),
		.state_nxt  (state_nxt),
		.count_nxt  (count_nxt),
		.result     (step_res)
	);

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_NORMAL, quote_open: 1'b0, skip_next: 1'b0,
				keep_escaped: 1'b0, error_seen: 1'b0, previous_byte: 8'h00};
			count_q <= '0;
		end else if (accept) begin
			state_q <= state_nxt;
			count_q <= count_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= step_res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_kind_q <= step_res.kind;
			out_byte_q <= step_res.data;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = out_kind_q;
	assign result_byte = out_byte_q;

endmodule

[rtl/msle_checker.sv]
module msle_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            end_of_file,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [1:0]                      result_kind,
	input logic [7:0]                      result_byte
);
	import msle_pkg::*;

	// A stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
			$stable(result_byte))
		else $error("result item changed while stalled");

	// Input is taken whenever the output side has room
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled with free output register");

	// End and trailing-backslash items carry a zero byte
	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_kind == KIND_LIT_END || result_kind == KIND_BSL_EOF)
			|-> result_byte == 8'h00)
		else $error("nonzero byte on end or backslash item");

	// A trailing-backslash error only comes from the last byte of a file
	a_bsl_eof: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !end_of_file |=> !(out_valid && result_kind == KIND_BSL_EOF))
		else $error("backslash error without end of file");

endmodule

bind macro_string_literal_extractor msle_checker u_msle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.end_of_file(end_of_file),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.result_kind(result_kind),
	.result_byte(result_byte)
);
